/* rtl/core/lpcp_pkg.sv */
// ----------------------------------------------------------------------------
// lpcp_pkg
// Shared widths, register indexes and helpers for the lidar point projection.
// ----------------------------------------------------------------------------
package lpcp_pkg;

  localparam int PointW = 24;
  localparam int CamW   = 42;   // |c| < 2^40, plus sign and margin
  localparam int MagW   = 41;   // |c| magnitude
  localparam int FocW   = 24;
  localparam int ProdW  = MagW + FocW;  // 65
  localparam int QuotW  = 41;   // quotient bits kept (flag at 2^40)
  localparam int PixW   = 16;
  localparam int CfgW   = 60;
  localparam int CfgIdxW = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_ROT0  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ROT1  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ROT2  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TRANS = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FOCAL = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_PRIN  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_WIDTH = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT = 3'd7;

  typedef struct packed {
    logic signed [PointW-1:0] x;
    logic signed [PointW-1:0] y;
    logic signed [PointW-1:0] z;
    logic                     last;
  } point_t;

endpackage

/* rtl/core/lpcp_stream_if.sv */
// ----------------------------------------------------------------------------
// lpcp_stream_if
// Valid/ready channel carrying one item of a given payload width.
// ----------------------------------------------------------------------------
interface lpcp_stream_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/lpcp_divider.sv */
// ----------------------------------------------------------------------------
// lpcp_divider
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Holds a sideband that travels with each item; advances only on enable.
// ----------------------------------------------------------------------------
module lpcp_divider
  import lpcp_pkg::*;
#(
  parameter int SideW = 1
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ProdW-1:0]      num,
  input  logic [MagW-1:0]       den,
  input  logic [SideW-1:0]      side_in,
  output logic [QuotW-1:0]      quot,
  output logic                  ovf,
  output logic [SideW-1:0]      side_out
);

  // Quotient may need 65 bits; only bits below 2^40 matter, anything above
  // is overflow. Pre-check: q >= 2^40 iff (num >> 40) >= den.
  localparam int Steps = QuotW - 1;  // 40 quotient bits
  localparam int RemW  = MagW + 1;

  logic [RemW-1:0]  rem_r  [Steps];
  logic [Steps-1:0] num_r  [Steps];
  logic [MagW-1:0]  den_r  [Steps];
  logic [Steps-1:0] q_r    [Steps+1];
  logic             ovf_r  [Steps+1];
  logic [SideW-1:0] side_r [Steps+1];

  // entry stage: overflow compare, remainder starts as num >> 40
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= RemW'(num[ProdW-1:Steps]);
      num_r[0]  <= num[Steps-1:0];
      den_r[0]  <= den;
      q_r[0]    <= '0;
      ovf_r[0]  <= (MagW'(num[ProdW-1:Steps]) >= den);
      side_r[0] <= side_in;
    end
  end

  // one quotient bit per stage, MSB first; remainder stays below den
  for (genvar s = 0; s < Steps; s++) begin : g_stage
    logic [RemW-1:0] shifted;
    logic [RemW-1:0] diff;
    always_comb begin
      shifted = {rem_r[s][RemW-2:0], num_r[s][Steps-1-s]};
      diff    = shifted - {1'b0, den_r[s]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ovf_r[s+1]  <= ovf_r[s];
        side_r[s+1] <= side_r[s];
        q_r[s+1]    <= {q_r[s][Steps-2:0], !diff[RemW-1]};
      end
    end
    if (s < Steps-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          num_r[s+1] <= num_r[s];
          den_r[s+1] <= den_r[s];
          rem_r[s+1] <= diff[RemW-1] ? shifted : diff;
        end
      end
    end
  end

  assign quot     = {1'b0, q_r[Steps]};
  assign ovf      = ovf_r[Steps];
  assign side_out = side_r[Steps];

endmodule

/* rtl/core/lidar_point_camera_projection.sv */
// ----------------------------------------------------------------------------
// lidar_point_camera_projection
// Moves a lidar point into the camera frame and projects it to a pixel.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one lidar point per item (x, y, z in Q13.10 metres, cloud_last).
//   out_* : one result per item: in_view, pixel column/row (0 when out of
//           view) and the input point and cloud_last passed through.
//   cfg_* : write enable, register index, 60-bit data; write only while idle.
// The pipeline has 45 register stages, and one item per cycle is sustained
// while out_ready is high or the output is empty. The depth is set by three
// front stages (rotation products, camera sums, magnitude times focal), the
// divider entry stage, 40 quotient stages (one bit each) and the output
// register.
// Reset clears all valid bits and loads an identity rotation with the other
// config registers zero. When the receiver stalls the whole pipeline holds
// in place (in_ready is out_ready || !out_valid), so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module lidar_point_camera_projection
  import lpcp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  lpcp_stream_if.sink        in_ch,
  lpcp_stream_if.source      out_ch,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  localparam int DivLat = QuotW;  // dividers: entry + 40 stages
  localparam int SideW  = $bits(point_t) + 2;

  // ---------------- configuration registers
  logic [47:0] rot_r [3];
  logic [59:0] trans_r;
  logic [47:0] focal_r, prin_r;
  logic [15:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= 48'h4000;
      rot_r[1] <= 48'h4000 << 16;
      rot_r[2] <= 48'h4000 << 32;
      trans_r  <= '0;
      focal_r  <= '0;
      prin_r   <= '0;
      width_r  <= '0;
      height_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROT0:   rot_r[0] <= cfg_data[47:0];
        REG_ROT1:   rot_r[1] <= cfg_data[47:0];
        REG_ROT2:   rot_r[2] <= cfg_data[47:0];
        REG_TRANS:  trans_r  <= cfg_data;
        REG_FOCAL:  focal_r  <= cfg_data[47:0];
        REG_PRIN:   prin_r   <= cfg_data[47:0];
        REG_WIDTH:  width_r  <= cfg_data[15:0];
        REG_HEIGHT: height_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // global stall: every stage advances together
  logic en;
  assign en          = out_ch.ready || !out_ch.valid;
  assign in_ch.ready = en;

  point_t pin;
  assign pin = point_t'(in_ch.data);

  // ---------------- stage 1: nine rotation products
  logic              v1_r;
  point_t            p1_r;
  logic signed [39:0] prod1_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= pin;
      for (int i = 0; i < 3; i++) begin
        prod1_r[i][0] <= 40'(signed'(rot_r[i][15:0])  * pin.x);
        prod1_r[i][1] <= 40'(signed'(rot_r[i][31:16]) * pin.y);
        prod1_r[i][2] <= 40'(signed'(rot_r[i][47:32]) * pin.z);
      end
    end
  end

  // ---------------- stage 2: camera coordinates
  logic              v2_r;
  point_t            p2_r;
  logic signed [CamW-1:0] cam2_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_r <= p1_r;
      for (int i = 0; i < 3; i++) begin
        cam2_r[i] <= CamW'(prod1_r[i][0]) + CamW'(prod1_r[i][1]) + CamW'(prod1_r[i][2])
                   + (CamW'(signed'(trans_r[20*i +: 20])) <<< 14);
      end
    end
  end

  // ---------------- stage 3: magnitudes and the numerator products
  logic              v3_r;
  point_t            p3_r;
  logic              front3_r;
  logic              neg3_r [2];
  logic [ProdW-1:0]  num3_r [2];
  logic [MagW-1:0]   den3_r;
  logic [MagW-1:0]   mag [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      mag[i] = cam2_r[i][CamW-1] ? MagW'(-cam2_r[i]) : MagW'(cam2_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_r     <= p2_r;
      front3_r <= !cam2_r[2][CamW-1] && (cam2_r[2] != '0);
      den3_r   <= (cam2_r[2][CamW-1] || cam2_r[2] == '0) ? MagW'(1) : MagW'(cam2_r[2]);
      neg3_r[0] <= cam2_r[0][CamW-1];
      neg3_r[1] <= cam2_r[1][CamW-1];
      num3_r[0] <= ProdW'(mag[0]) * ProdW'(focal_r[23:0]);
      num3_r[1] <= ProdW'(mag[1]) * ProdW'(focal_r[47:24]);
    end
  end

  // ---------------- dividers
  logic [QuotW-1:0] q [2];
  logic             ovf [2];
  logic [SideW-1:0] side_c;
  logic             negr;

  lpcp_divider #(.SideW(SideW)) u_div_col (
    .clk(clk), .en(en), .num(num3_r[0]), .den(den3_r),
    .side_in({p3_r, neg3_r[0], front3_r}),
    .quot(q[0]), .ovf(ovf[0]), .side_out(side_c)
  );

  lpcp_divider #(.SideW(1)) u_div_row (
    .clk(clk), .en(en), .num(num3_r[1]), .den(den3_r),
    .side_in(neg3_r[1]), .quot(q[1]), .ovf(ovf[1]), .side_out(negr)
  );

  // valid pipe through divider latency
  logic [DivLat-1:0] vdiv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vdiv_r <= '0;
    else if (en) vdiv_r <= {vdiv_r[DivLat-2:0], v3_r};
  end

  // ---------------- final stage: offset, truncate, bounds
  point_t pd;
  logic   negc, frontd;
  assign {pd, negc, frontd} = side_c;

  logic signed [42:0] sc, sr;
  logic signed [35:0] colp, rowp;
  logic               view;
  always_comb begin
    sc = (negc ? -$signed({2'b0, q[0]}) : $signed({2'b0, q[0]})) + 43'(prin_r[23:0]);
    sr = (negr ? -$signed({2'b0, q[1]}) : $signed({2'b0, q[1]})) + 43'(prin_r[47:24]);
    // truncate toward zero: add 255 for negatives before shifting
    colp = 36'((sc + (sc[42] ? 43'sd255 : 43'sd0)) >>> 8);
    rowp = 36'((sr + (sr[42] ? 43'sd255 : 43'sd0)) >>> 8);
    view = frontd && !ovf[0] && !ovf[1] && !colp[35] && !rowp[35]
        && (colp < 36'(width_r)) && (rowp < 36'(height_r));
  end

  logic              vo_r;
  logic              view_r;
  logic [PixW-1:0]   col_r, row_r;
  point_t            po_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (en) vo_r <= vdiv_r[DivLat-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      view_r <= view;
      col_r  <= view ? colp[PixW-1:0] : '0;
      row_r  <= view ? rowp[PixW-1:0] : '0;
      po_r   <= pd;
    end
  end

  assign out_ch.valid = vo_r;
  assign out_ch.data  = {view_r, col_r, row_r, po_r.x, po_r.y, po_r.z, po_r.last};

  // ---------------- checks
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped under stall");
  a_zero_pix: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !view_r |-> col_r == '0 && row_r == '0)
    else $error("pixel not cleared out of view");
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && view_r |-> col_r < width_r && row_r < height_r)
    else $error("pixel outside image");

endmodule
